// File: rtl/stack_machine_execute_defines.svh
// Assertion macros shared by the stack machine RTL.
// Used by smx_front and smx_back; relies on clk_i and rst_ni in the using module.
`ifndef STACK_MACHINE_EXECUTE_DEFINES_SVH
`define STACK_MACHINE_EXECUTE_DEFINES_SVH

`ifndef SYNTHESIS

`define SMX_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("smx assertion failed");

`define SMX_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("smx assertion failed");

`else

`define SMX_ASSERT_IMP(lbl, ante, cons)

`define SMX_ASSERT_NXT(lbl, ante, cons)

`endif

`endif

// File: rtl/smx_pkg.sv
// Package for the stack machine: opcodes, fault codes, decoded word type, defaults.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package smx_pkg;

  localparam int MEM_DEPTH_DEF  = 1024;
  localparam int WORD_WIDTH_DEF = 32;
  localparam int QUEUE_DEPTH    = 2;

  typedef enum logic [4:0] {
    OP_START, OP_LDC, OP_LDV, OP_ADD, OP_SUB, OP_MULT, OP_DIVI, OP_INV,
    OP_AND, OP_OR, OP_NEG, OP_CME, OP_CMA, OP_CEQ, OP_CDIF, OP_CMEQ,
    OP_CMAQ, OP_JMP, OP_JMPF, OP_STR, OP_ALLOC, OP_DALLOC, OP_CALL,
    OP_RETURN, OP_HLT, OP_RD, OP_PRN, OP_NOP
  } op_e;

  typedef enum logic [1:0] {
    F_NONE, F_DIV, F_STACK, F_ADDR
  } fault_e;

  typedef struct packed {
    op_e         op;
    logic [31:0] operand;
    logic [10:0] count;
    logic [31:0] read_value;
    logic        tgt_ok;
  } item_t;

endpackage

`default_nettype wire

// File: rtl/smx_front.sv
// Front end: accepts instruction words, decodes the opcode, queues decoded words.
// Depends on smx_pkg and stack_machine_execute_defines.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "stack_machine_execute_defines.svh"

module smx_front import smx_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        push_i,
  input  wire logic [4:0]  kind_i,
  input  wire logic [31:0] operand_i,
  input  wire logic [10:0] count_i,
  input  wire logic [31:0] read_value_i,
  output logic             full_o,
  output logic             item_valid_o,
  output item_t            item_o,
  input  wire logic        item_pop_i
);

  localparam int QPW = $clog2(QUEUE_DEPTH);
  localparam int QCW = $clog2(QUEUE_DEPTH + 1);

  item_t          q_mem [QUEUE_DEPTH];
  logic [QPW-1:0] wp_q, wp_d, rp_q, rp_d;
  logic [QCW-1:0] cnt_q, cnt_d;
  item_t          dec;

  always_comb begin
    dec.op         = (kind_i > 5'(OP_NOP)) ? OP_NOP : op_e'(kind_i);
    dec.operand    = operand_i;
    dec.count      = count_i;
    dec.read_value = read_value_i;
    dec.tgt_ok     = (operand_i[31:16] == 16'd0);
  end

  assign full_o       = (cnt_q == QCW'(QUEUE_DEPTH));
  assign item_valid_o = (cnt_q != '0);
  assign item_o       = q_mem[rp_q];

  always_comb begin
    wp_d  = wp_q;
    rp_d  = rp_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wp_d = (wp_q == QPW'(QUEUE_DEPTH - 1)) ? '0 : wp_q + 1'b1;
    end
    if (item_pop_i) begin
      rp_d = (rp_q == QPW'(QUEUE_DEPTH - 1)) ? '0 : rp_q + 1'b1;
    end
    if (push_i && !item_pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!push_i && item_pop_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      q_mem[wp_q] <= dec;
    end
  end

  `SMX_ASSERT_IMP(a_no_overrun, push_i, !full_o || item_pop_i)
  `SMX_ASSERT_IMP(a_no_underrun, item_pop_i, item_valid_o)
  `SMX_ASSERT_IMP(a_cnt_range, 1'b1, cnt_q <= QCW'(QUEUE_DEPTH))

endmodule

`default_nettype wire

// File: rtl/smx_md.sv
// Shared multiply and divide unit, one bit per cycle (shift-add, restoring divide).
// Depends on smx_pkg.
`timescale 1ns / 1ps
`default_nettype none

module smx_md import smx_pkg::*; #(
  parameter int WORD_WIDTH = WORD_WIDTH_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  start_i,
  input  wire logic                  div_i,
  input  wire logic [WORD_WIDTH-1:0] a_i,
  input  wire logic [WORD_WIDTH-1:0] b_i,
  output logic                       done_o,
  output logic [WORD_WIDTH-1:0]      res_o
);

  localparam int WW = WORD_WIDTH;
  localparam int CW = $clog2(WW + 1);

  logic          busy_q, done_q;
  logic [CW-1:0] cnt_q;
  logic          div_q, neg_q;
  logic [WW-1:0] x_q, y_q, acc_q;
  logic [WW:0]   trial;
  logic          ge;

  assign trial  = {acc_q, x_q[WW-1]};
  assign ge     = (trial >= {1'b0, y_q});
  assign done_o = done_q;
  assign res_o  = div_q ? (neg_q ? (WW'(0) - x_q) : x_q) : acc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(WW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      div_q <= div_i;
      neg_q <= a_i[WW-1] ^ b_i[WW-1];
      acc_q <= '0;
      if (div_i) begin
        x_q <= a_i[WW-1] ? (WW'(0) - a_i) : a_i;
        y_q <= b_i[WW-1] ? (WW'(0) - b_i) : b_i;
      end else begin
        x_q <= a_i;
        y_q <= b_i;
      end
    end else if (busy_q) begin
      if (div_q) begin
        acc_q <= ge ? WW'(trial - {1'b0, y_q}) : trial[WW-1:0];
        x_q   <= {x_q[WW-2:0], ge};
      end else begin
        acc_q <= x_q[0] ? (acc_q + y_q) : acc_q;
        y_q   <= {y_q[WW-2:0], 1'b0};
        x_q   <= {1'b0, x_q[WW-1:1]};
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/smx_back.sv
// Back end: sequencer that executes decoded words against the data/stack memory.
// Depends on smx_pkg, smx_md and stack_machine_execute_defines.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "stack_machine_execute_defines.svh"

module smx_back import smx_pkg::*; #(
  parameter int MEM_DEPTH  = MEM_DEPTH_DEF,
  parameter int WORD_WIDTH = WORD_WIDTH_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        item_valid_i,
  input  wire item_t       item_i,
  output logic             item_pop_o,
  output logic             clearing_o,
  output logic             out_empty_o,
  input  wire logic        out_pop_i,
  output logic [15:0]      next_pc_o,
  output logic [31:0]      top_value_o,
  output logic [10:0]      stack_level_o,
  output logic             print_valid_o,
  output logic [31:0]      print_value_o,
  output logic             halted_o,
  output logic [1:0]       fault_o
);

  localparam int WW = WORD_WIDTH;
  localparam int AW = $clog2(MEM_DEPTH);
  localparam int LW = AW + 1;
  localparam int SW = ((LW > 11) ? LW : 11) + 1;

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_RA, S_EX, S_MD, S_CP_RD, S_CP_WR, S_TOP, S_OUT
  } st_e;

  logic [WW-1:0] mem [MEM_DEPTH];
  logic [WW-1:0] rd_q;
  logic          we, re;
  logic [AW-1:0] wa, ra;
  logic [WW-1:0] wd;

  st_e           state_q, state_d;
  item_t         it_q, it_d;
  logic [WW-1:0] b_q, b_d;
  logic [LW-1:0] lvl_q, lvl_d;
  logic [15:0]   pc_q, pc_d;
  logic [AW-1:0] clr_q, clr_d;
  logic [10:0]   cp_n_q, cp_n_d;
  logic [AW-1:0] cp_a_q, cp_a_d;
  logic [15:0]   r_pc_q, r_pc_d;
  logic          r_pv_q, r_pv_d;
  logic [WW-1:0] r_pval_q, r_pval_d;
  logic          r_halt_q, r_halt_d;
  fault_e        r_fault_q, r_fault_d;
  logic          o_valid_q, o_valid_d;
  logic [15:0]   o_pc_q, o_pc_d;
  logic [31:0]   o_top_q, o_top_d;
  logic [10:0]   o_lvl_q, o_lvl_d;
  logic          o_pv_q, o_pv_d;
  logic [31:0]   o_pval_q, o_pval_d;
  logic          o_halt_q, o_halt_d;
  fault_e        o_fault_q, o_fault_d;

  logic          md_start, md_done;
  logic [WW-1:0] md_res;

  logic [LW-1:0] lvl_m1, lvl_m2;
  logic [AW-1:0] tos_a, sub_a, push_a;
  logic          empty, le_one, full;
  logic [WW-1:0] opw, rdw, bin_r;
  logic          addr_ok, rng_ok, alloc_ovf, dalloc_unf;
  logic [32:0]   d_last;
  logic [15:0]   npc1;

  assign lvl_m1     = lvl_q - LW'(1);
  assign lvl_m2     = lvl_q - LW'(2);
  assign tos_a      = lvl_m1[AW-1:0];
  assign sub_a      = lvl_m2[AW-1:0];
  assign push_a     = lvl_q[AW-1:0];
  assign empty      = (lvl_q == '0);
  assign le_one     = (lvl_q < LW'(2));
  assign full       = (lvl_q == LW'(MEM_DEPTH));
  assign opw        = WW'($signed(it_q.operand));
  assign rdw        = WW'($signed(it_q.read_value));
  assign addr_ok    = (33'(it_q.operand) < 33'(MEM_DEPTH));
  assign rng_ok     = ((33'(it_q.operand) + 33'(it_q.count)) <= 33'(MEM_DEPTH));
  assign alloc_ovf  = ((SW'(lvl_q) + SW'(it_q.count)) > SW'(MEM_DEPTH));
  assign dalloc_unf = (SW'(it_q.count) > SW'(lvl_q));
  assign d_last     = 33'(it_q.operand) + 33'(it_q.count) - 33'(1);
  assign npc1       = pc_q + 16'd1;

  always_comb begin
    bin_r = '0;
    case (it_q.op)
      OP_ADD:  bin_r = rd_q + b_q;
      OP_SUB:  bin_r = rd_q - b_q;
      OP_AND:  bin_r = WW'((rd_q == WW'(1)) && (b_q == WW'(1)));
      OP_OR:   bin_r = WW'((rd_q == WW'(1)) || (b_q == WW'(1)));
      OP_CME:  bin_r = WW'($signed(rd_q) < $signed(b_q));
      OP_CMA:  bin_r = WW'($signed(b_q) < $signed(rd_q));
      OP_CEQ:  bin_r = WW'(rd_q == b_q);
      OP_CDIF: bin_r = WW'(rd_q != b_q);
      OP_CMEQ: bin_r = WW'(!($signed(b_q) < $signed(rd_q)));
      OP_CMAQ: bin_r = WW'(!($signed(rd_q) < $signed(b_q)));
      default: bin_r = '0;
    endcase
  end

  always_comb begin
    fault_e      flt;
    logic [15:0] npc;
    state_d    = state_q;
    it_d       = it_q;
    b_d        = b_q;
    lvl_d      = lvl_q;
    pc_d       = pc_q;
    clr_d      = clr_q;
    cp_n_d     = cp_n_q;
    cp_a_d     = cp_a_q;
    r_pc_d     = r_pc_q;
    r_pv_d     = r_pv_q;
    r_pval_d   = r_pval_q;
    r_halt_d   = r_halt_q;
    r_fault_d  = r_fault_q;
    o_valid_d  = o_valid_q && !out_pop_i;
    o_pc_d     = o_pc_q;
    o_top_d    = o_top_q;
    o_lvl_d    = o_lvl_q;
    o_pv_d     = o_pv_q;
    o_pval_d   = o_pval_q;
    o_halt_d   = o_halt_q;
    o_fault_d  = o_fault_q;
    we         = 1'b0;
    wa         = '0;
    wd         = '0;
    re         = 1'b0;
    ra         = '0;
    item_pop_o = 1'b0;
    md_start   = 1'b0;
    flt        = F_NONE;
    npc        = npc1;

    unique case (state_q)
      S_CLR: begin
        we = 1'b1;
        wa = clr_q;
        if (clr_q == AW'(MEM_DEPTH - 1)) begin
          state_d = S_IDLE;
        end else begin
          clr_d = clr_q + 1'b1;
        end
      end
      S_IDLE: begin
        if (item_valid_i) begin
          item_pop_o = 1'b1;
          it_d       = item_i;
          re         = 1'b1;
          ra         = tos_a;
          state_d    = S_RA;
        end
      end
      S_RA: begin
        b_d     = rd_q;
        re      = 1'b1;
        ra      = (it_q.op == OP_LDV) ? it_q.operand[AW-1:0] : sub_a;
        state_d = S_EX;
      end
      S_EX: begin
        r_pv_d   = 1'b0;
        r_pval_d = '0;
        r_halt_d = 1'b0;
        state_d  = S_TOP;
        unique case (it_q.op)
          OP_START: lvl_d = '0;
          OP_LDC, OP_RD: begin
            if (full) begin
              flt = F_STACK;
            end else begin
              we    = 1'b1;
              wa    = push_a;
              wd    = (it_q.op == OP_LDC) ? opw : rdw;
              lvl_d = lvl_q + 1'b1;
            end
          end
          OP_LDV: begin
            if (full) begin
              flt = F_STACK;
            end else if (!addr_ok) begin
              flt = F_ADDR;
            end else begin
              we    = 1'b1;
              wa    = push_a;
              wd    = rd_q;
              lvl_d = lvl_q + 1'b1;
            end
          end
          OP_ADD, OP_SUB, OP_MULT, OP_DIVI, OP_AND, OP_OR, OP_CME, OP_CMA,
          OP_CEQ, OP_CDIF, OP_CMEQ, OP_CMAQ: begin
            if (le_one) begin
              flt = F_STACK;
            end else if (it_q.op == OP_DIVI && b_q == '0) begin
              flt = F_DIV;
            end else if (it_q.op == OP_MULT || it_q.op == OP_DIVI) begin
              md_start = 1'b1;
              state_d  = S_MD;
            end else begin
              we    = 1'b1;
              wa    = sub_a;
              wd    = bin_r;
              lvl_d = lvl_m1;
            end
          end
          OP_INV, OP_NEG: begin
            if (empty) begin
              flt = F_STACK;
            end else begin
              we = 1'b1;
              wa = tos_a;
              wd = ((it_q.op == OP_INV) ? WW'(0) : WW'(1)) - b_q;
            end
          end
          OP_JMP: begin
            if (!it_q.tgt_ok) begin
              flt = F_ADDR;
            end else begin
              npc = it_q.operand[15:0];
            end
          end
          OP_JMPF: begin
            if (empty) begin
              flt = F_STACK;
            end else if (b_q == '0) begin
              if (!it_q.tgt_ok) begin
                flt = F_ADDR;
              end else begin
                npc   = it_q.operand[15:0];
                lvl_d = lvl_m1;
              end
            end else begin
              lvl_d = lvl_m1;
            end
          end
          OP_STR: begin
            if (empty) begin
              flt = F_STACK;
            end else if (!addr_ok) begin
              flt = F_ADDR;
            end else begin
              we    = 1'b1;
              wa    = it_q.operand[AW-1:0];
              wd    = b_q;
              lvl_d = lvl_m1;
            end
          end
          OP_ALLOC: begin
            if (it_q.count != '0) begin
              if (alloc_ovf) begin
                flt = F_STACK;
              end else if (!rng_ok) begin
                flt = F_ADDR;
              end else begin
                cp_n_d  = it_q.count;
                cp_a_d  = it_q.operand[AW-1:0];
                state_d = S_CP_RD;
              end
            end
          end
          OP_DALLOC: begin
            if (it_q.count != '0) begin
              if (dalloc_unf) begin
                flt = F_STACK;
              end else if (!rng_ok) begin
                flt = F_ADDR;
              end else begin
                cp_n_d  = it_q.count;
                cp_a_d  = d_last[AW-1:0];
                state_d = S_CP_RD;
              end
            end
          end
          OP_CALL: begin
            if (full) begin
              flt = F_STACK;
            end else if (!it_q.tgt_ok) begin
              flt = F_ADDR;
            end else begin
              we    = 1'b1;
              wa    = push_a;
              wd    = WW'(npc1);
              lvl_d = lvl_q + 1'b1;
              npc   = it_q.operand[15:0];
            end
          end
          OP_RETURN: begin
            if (empty) begin
              flt = F_STACK;
            end else if (b_q[WW-1] || (64'(b_q) > 64'hFFFF)) begin
              flt = F_ADDR;
            end else begin
              npc   = 16'(b_q);
              lvl_d = lvl_m1;
            end
          end
          OP_HLT: begin
            npc      = 16'd0;
            r_halt_d = 1'b1;
          end
          OP_PRN: begin
            if (empty) begin
              flt = F_STACK;
            end else begin
              r_pv_d   = 1'b1;
              r_pval_d = b_q;
              lvl_d    = lvl_m1;
            end
          end
          OP_NOP: begin
          end
          default: begin
          end
        endcase
        r_fault_d = flt;
        r_pc_d    = (flt != F_NONE) ? pc_q : npc;
        pc_d      = r_pc_d;
      end
      S_MD: begin
        if (md_done) begin
          we      = 1'b1;
          wa      = sub_a;
          wd      = md_res;
          lvl_d   = lvl_m1;
          state_d = S_TOP;
        end
      end
      S_CP_RD: begin
        re      = 1'b1;
        ra      = (it_q.op == OP_ALLOC) ? cp_a_q : tos_a;
        state_d = S_CP_WR;
      end
      S_CP_WR: begin
        we     = 1'b1;
        wd     = rd_q;
        cp_n_d = cp_n_q - 1'b1;
        if (it_q.op == OP_ALLOC) begin
          wa     = push_a;
          lvl_d  = lvl_q + 1'b1;
          cp_a_d = cp_a_q + 1'b1;
        end else begin
          wa     = cp_a_q;
          lvl_d  = lvl_m1;
          cp_a_d = cp_a_q - 1'b1;
        end
        state_d = (cp_n_q == 11'd1) ? S_TOP : S_CP_RD;
      end
      S_TOP: begin
        re      = 1'b1;
        ra      = tos_a;
        state_d = S_OUT;
      end
      S_OUT: begin
        if (!o_valid_q || out_pop_i) begin
          o_valid_d = 1'b1;
          o_pc_d    = r_pc_q;
          o_top_d   = empty ? 32'd0 : 32'($signed(rd_q));
          o_lvl_d   = 11'($signed(lvl_m1));
          o_pv_d    = r_pv_q;
          o_pval_d  = 32'($signed(r_pval_q));
          o_halt_d  = r_halt_q;
          o_fault_d = r_fault_q;
          state_d   = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_CLR;
      lvl_q     <= '0;
      pc_q      <= '0;
      clr_q     <= '0;
      o_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      lvl_q     <= lvl_d;
      pc_q      <= pc_d;
      clr_q     <= clr_d;
      o_valid_q <= o_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    it_q      <= it_d;
    b_q       <= b_d;
    cp_n_q    <= cp_n_d;
    cp_a_q    <= cp_a_d;
    r_pc_q    <= r_pc_d;
    r_pv_q    <= r_pv_d;
    r_pval_q  <= r_pval_d;
    r_halt_q  <= r_halt_d;
    r_fault_q <= r_fault_d;
    o_pc_q    <= o_pc_d;
    o_top_q   <= o_top_d;
    o_lvl_q   <= o_lvl_d;
    o_pv_q    <= o_pv_d;
    o_pval_q  <= o_pval_d;
    o_halt_q  <= o_halt_d;
    o_fault_q <= o_fault_d;
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[wa] <= wd;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re) begin
      rd_q <= mem[ra];
    end
  end

  smx_md #(
    .WORD_WIDTH(WORD_WIDTH)
  ) u_md (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(md_start),
    .div_i  (it_q.op == OP_DIVI),
    .a_i    (rd_q),
    .b_i    (b_q),
    .done_o (md_done),
    .res_o  (md_res)
  );

  assign clearing_o    = (state_q == S_CLR);
  assign out_empty_o   = !o_valid_q;
  assign next_pc_o     = o_pc_q;
  assign top_value_o   = o_top_q;
  assign stack_level_o = o_lvl_q;
  assign print_valid_o = o_pv_q;
  assign print_value_o = o_pval_q;
  assign halted_o      = o_halt_q;
  assign fault_o       = o_fault_q;

  `SMX_ASSERT_IMP(a_fault_no_write, (state_q == S_EX) && (r_fault_d != F_NONE), !we)
  `SMX_ASSERT_IMP(a_level_range, 1'b1, lvl_q <= LW'(MEM_DEPTH))
  `SMX_ASSERT_IMP(a_pop_idle, item_pop_o, (state_q == S_IDLE) && item_valid_i)
  `SMX_ASSERT_NXT(a_md_start, md_start, state_q == S_MD)

endmodule

`default_nettype wire

// File: rtl/stack_machine_execute.sv
// Top level of the stack machine executor: front decode queue plus execution back end.
// Depends on smx_pkg, smx_front and smx_back.
//
//  channel   | direction | handshake          | payload
//  ----------+-----------+--------------------+---------------------------------------------
//  input     | in        | push / full        | kind, operand, count, read_value
//  result    | out       | pop / empty        | next_pc, top_value, stack_level, print_*,
//            |           |                    | halted, fault
//
// Most words pass through the execution sequencer as stack read, second read, execute,
// top-of-stack read and result load.
// MULT and DIVI also pass through the bit-serial multiply/divide unit.
// ALLOC and DALLOC copy each word with one memory read and one write.
// After reset the data memory is cleared word by word; full stays high meanwhile.
// A two-word queue after decode keeps accepting while a result waits to be popped.
`timescale 1ns / 1ps
`default_nettype none

module stack_machine_execute import smx_pkg::*; #(
  parameter int MEM_DEPTH  = MEM_DEPTH_DEF,
  parameter int WORD_WIDTH = WORD_WIDTH_DEF
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               push,
  output logic                    full,
  input  wire logic [4:0]         kind_i,
  input  wire logic signed [31:0] operand_i,
  input  wire logic [10:0]        count_i,
  input  wire logic signed [31:0] read_value_i,
  output logic                    empty,
  input  wire logic               pop,
  output logic [15:0]             next_pc_o,
  output logic signed [31:0]      top_value_o,
  output logic signed [10:0]      stack_level_o,
  output logic                    print_valid_o,
  output logic signed [31:0]      print_value_o,
  output logic                    halted_o,
  output logic [1:0]              fault_o
);

  logic  q_full, clearing, push_ok, item_valid, item_pop, out_empty;
  item_t item;

  assign full    = q_full || clearing;
  assign push_ok = push && !full;
  assign empty   = out_empty;

  smx_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push_ok),
    .kind_i      (kind_i),
    .operand_i   (operand_i),
    .count_i     (count_i),
    .read_value_i(read_value_i),
    .full_o      (q_full),
    .item_valid_o(item_valid),
    .item_o      (item),
    .item_pop_i  (item_pop)
  );

  smx_back #(
    .MEM_DEPTH (MEM_DEPTH),
    .WORD_WIDTH(WORD_WIDTH)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (item_valid),
    .item_i       (item),
    .item_pop_o   (item_pop),
    .clearing_o   (clearing),
    .out_empty_o  (out_empty),
    .out_pop_i    (pop),
    .next_pc_o    (next_pc_o),
    .top_value_o  (top_value_o),
    .stack_level_o(stack_level_o),
    .print_valid_o(print_valid_o),
    .print_value_o(print_value_o),
    .halted_o     (halted_o),
    .fault_o      (fault_o)
  );

endmodule

`default_nettype wire
